/* rtl/mean_nearest_distance_to_set_defines.svh */
// Assertion macros used by the bound checker file.
`ifndef MEAN_NEAREST_DISTANCE_TO_SET_DEFINES_SVH
`define MEAN_NEAREST_DISTANCE_TO_SET_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MNDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mnds assertion failed");

// Next-cycle implication, held off during reset.
`define MNDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mnds assertion failed");

`endif

/* rtl/mnds_pkg.sv */
`default_nettype none
package mnds_pkg;

  localparam int REF_MAX   = 256;
  localparam int DIM_MAX   = 8;
  localparam int ROW_W     = $clog2(REF_MAX);
  localparam int COL_W     = $clog2(DIM_MAX);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int RAM_DEPTH = REF_MAX * DIM_MAX;
  localparam int DATA_W    = 32;
  localparam int DIMS_W    = 4;
  localparam int REFS_W    = 9;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 16;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 48;
  localparam int STEP_W    = 6;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [DATA_W-1:0] DIST_MAX = '1;

  // Register selects (address bit 2)
  localparam logic REG_DIM = 1'b0;
  localparam logic REG_REF = 1'b1;

  typedef enum logic [1:0] {
    OP_REF,
    OP_QUERY,
    OP_QLAST
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last_point;
  } item_t;

  typedef struct packed {
    logic [DIMS_W-1:0] dimension_count;
    logic [REFS_W-1:0] reference_count;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/mnds_ram.sv */
`default_nettype none
module mnds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/mnds_front.sv */
`default_nettype none
module mnds_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          command,
  input  logic [mnds_pkg::ROW_W-1:0]    ref_index,
  input  logic [mnds_pkg::COL_W-1:0]    coord_index,
  input  logic [mnds_pkg::DATA_W-1:0]   coord_value,
  input  logic                          last_coord,
  input  logic                          last_point,
  output logic                          busy,
  output mnds_pkg::item_t               item,
  output logic                          item_valid,
  input  logic                          item_pop
);

  mnds_pkg::item_t             fifo [mnds_pkg::QDEPTH];
  mnds_pkg::item_t             in_item;
  logic [mnds_pkg::QPTR_W-1:0] wr_ptr;
  logic [mnds_pkg::QPTR_W-1:0] rd_ptr;
  logic [mnds_pkg::QCNT_W-1:0] fill;
  logic                        push;

  assign busy       = (fill == mnds_pkg::QCNT_W'(mnds_pkg::QDEPTH));
  assign push       = start && !busy;
  assign item_valid = (fill != '0);
  assign item       = fifo[rd_ptr];

  // Classify: reference write, query coordinate, or last coordinate of a query
  always_comb begin
    in_item.row        = ref_index;
    in_item.col        = coord_index;
    in_item.value      = coord_value;
    in_item.last_point = last_point;
    priority if (!command) begin
      in_item.op = mnds_pkg::OP_REF;
    end else if (last_coord) begin
      in_item.op = mnds_pkg::OP_QLAST;
    end else begin
      in_item.op = mnds_pkg::OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mnds_pkg::QPTR_W'(mnds_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == mnds_pkg::QPTR_W'(mnds_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, item_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mnds_back.sv */
`default_nettype none
module mnds_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mnds_pkg::item_t             item,
  input  logic                        item_valid,
  output logic                        item_pop,
  input  mnds_pkg::cfg_t              cfg,
  output logic                        res_valid,
  output logic [mnds_pkg::DATA_W-1:0] point_distance,
  output logic [mnds_pkg::DATA_W-1:0] mean_distance,
  output logic                        mean_valid,
  output logic                        empty_reference
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SQRT,
    S_ACC,
    S_DIV
  } state_t;

  state_t state;

  logic [mnds_pkg::DIMS_W-1:0] dims_eff;
  logic [mnds_pkg::REFS_W-1:0] refs_eff;
  logic [mnds_pkg::COL_W-1:0]  col_last;
  logic [mnds_pkg::ROW_W-1:0]  row_last;

  always_comb begin
    priority if (cfg.dimension_count == '0) begin
      dims_eff = mnds_pkg::DIMS_W'(1);
    end else if (cfg.dimension_count > mnds_pkg::DIMS_W'(mnds_pkg::DIM_MAX)) begin
      dims_eff = mnds_pkg::DIMS_W'(mnds_pkg::DIM_MAX);
    end else begin
      dims_eff = cfg.dimension_count;
    end
    priority if (cfg.reference_count > mnds_pkg::REFS_W'(mnds_pkg::REF_MAX)) begin
      refs_eff = mnds_pkg::REFS_W'(mnds_pkg::REF_MAX);
    end else begin
      refs_eff = cfg.reference_count;
    end
  end

  assign col_last = mnds_pkg::COL_W'(dims_eff - 1'b1);
  assign row_last = mnds_pkg::ROW_W'(refs_eff - 1'b1);

  // Query coordinates
  logic [mnds_pkg::DATA_W-1:0] qbuf [mnds_pkg::DIM_MAX];

  // Search walk and pipeline
  logic [mnds_pkg::ROW_W-1:0]  row;
  logic [mnds_pkg::COL_W-1:0]  col;
  logic                        issuing;
  logic                        s1_v, s1_last;
  logic [mnds_pkg::COL_W-1:0]  s1_col;
  logic                        s2_v, s2_last;
  logic [31:0]                 s2_mag;
  logic                        s3_v, s3_last;
  logic [63:0]                 s3_prod;
  logic [63:0]                 acc;
  logic [63:0]                 best;
  logic [mnds_pkg::DATA_W-1:0] rdata;
  logic [mnds_pkg::DATA_W-1:0] qv;
  logic signed [32:0]          diff;
  logic [32:0]                 mag33;
  logic [64:0]                 acc_sum;
  logic [63:0]                 acc_sat;

  logic ram_we;
  assign item_pop = (state == S_IDLE) && item_valid;
  assign ram_we   = item_pop && (item.op == mnds_pkg::OP_REF);

  mnds_ram #(
    .WIDTH (mnds_pkg::DATA_W),
    .DEPTH (mnds_pkg::RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({item.row, item.col}),
    .wdata (item.value),
    .raddr ({row, col}),
    .rdata (rdata)
  );

  assign qv      = qbuf[s1_col];
  assign diff    = $signed({qv[31], qv}) - $signed({rdata[31], rdata});
  assign mag33   = diff[32] ? 33'(-diff) : 33'(diff);
  assign acc_sum = {1'b0, acc} + {1'b0, s3_prod};
  assign acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];

  // Square root, two radicand bits a step
  logic [63:0]                 sq_n;
  logic [34:0]                 sq_rem;
  logic [31:0]                 sq_root;
  logic [34:0]                 sq_rem2;
  logic [34:0]                 sq_trial;
  logic                        sq_ge;
  logic [31:0]                 sq_root_next;
  logic [mnds_pkg::STEP_W-1:0] step;

  assign sq_rem2      = {sq_rem[32:0], sq_n[63:62]};
  assign sq_trial     = {1'b0, sq_root, 2'b01};
  assign sq_ge        = (sq_rem2 >= sq_trial);
  assign sq_root_next = {sq_root[30:0], sq_ge};

  // Running sum, count and restoring divider
  logic [mnds_pkg::DATA_W-1:0] pt_dist;
  logic                        cur_last, cur_empty;
  logic [mnds_pkg::SUM_W-1:0]  dist_sum;
  logic [mnds_pkg::CNT_W-1:0]  count;
  logic [mnds_pkg::SUM_W:0]    sum_wide;
  logic [mnds_pkg::SUM_W-1:0]  sum_next;
  logic [mnds_pkg::CNT_W-1:0]  count_next;
  logic [mnds_pkg::SUM_W-1:0]  dv_q;
  logic [mnds_pkg::CNT_W-1:0]  dv_rem;
  logic [mnds_pkg::CNT_W:0]    dv_rem2;
  logic                        dv_ge;
  logic [mnds_pkg::SUM_W-1:0]  dv_q_next;
  logic [mnds_pkg::DATA_W-1:0] mean_calc;

  assign sum_wide   = {1'b0, dist_sum} + (mnds_pkg::SUM_W + 1)'(pt_dist);
  assign sum_next   = sum_wide[mnds_pkg::SUM_W] ? '1 : sum_wide[mnds_pkg::SUM_W-1:0];
  assign count_next = (&count) ? count : count + 1'b1;
  assign dv_rem2    = {dv_rem, dv_q[mnds_pkg::SUM_W-1]};
  assign dv_ge      = (dv_rem2 >= {1'b0, count});
  assign dv_q_next  = {dv_q[mnds_pkg::SUM_W-2:0], dv_ge};

  always_comb begin
    priority if (cur_last && cur_empty) begin
      mean_calc = mnds_pkg::DIST_MAX;
    end else if (dv_q_next[mnds_pkg::SUM_W-1:mnds_pkg::DATA_W] != '0) begin
      mean_calc = mnds_pkg::DIST_MAX;
    end else begin
      mean_calc = dv_q_next[mnds_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && (item.op != mnds_pkg::OP_REF)) begin
      qbuf[item.col] <= item.value;
    end
    s1_col  <= col;
    s2_mag  <= mag33[31:0];
    s3_prod <= s2_mag * s2_mag;
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s1_last   <= 1'b0;
      s2_last   <= 1'b0;
      s3_last   <= 1'b0;
      dist_sum  <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      row       <= '0;
      col       <= '0;
    end else begin
      res_valid <= 1'b0;
      s1_v      <= issuing;
      s1_last   <= (col == col_last);
      s2_v      <= s1_v;
      s2_last   <= s1_last;
      s3_v      <= s2_v;
      s3_last   <= s2_last;
      unique case (state)
        S_IDLE: begin
          if (item_pop && (item.op == mnds_pkg::OP_QLAST)) begin
            cur_last  <= item.last_point;
            cur_empty <= (refs_eff == '0);
            if (refs_eff == '0) begin
              pt_dist <= mnds_pkg::DIST_MAX;
              state   <= S_ACC;
            end else begin
              row     <= '0;
              col     <= '0;
              acc     <= '0;
              best    <= '1;
              issuing <= 1'b1;
              state   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (issuing) begin
            if (col == col_last) begin
              col <= '0;
              if (row == row_last) begin
                issuing <= 1'b0;
              end else begin
                row <= row + 1'b1;
              end
            end else begin
              col <= col + 1'b1;
            end
          end
          if (s3_v) begin
            if (s3_last) begin
              acc <= '0;
              if (acc_sat < best) begin
                best <= acc_sat;
              end
            end else begin
              acc <= acc_sat;
            end
          end
          if (!issuing && !s1_v && !s2_v && !s3_v) begin
            sq_n    <= best;
            sq_rem  <= '0;
            sq_root <= '0;
            step    <= '0;
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_n    <= {sq_n[61:0], 2'b00};
          sq_rem  <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
          sq_root <= sq_root_next;
          step    <= step + 1'b1;
          if (step == mnds_pkg::STEP_W'(mnds_pkg::SQ_STEPS - 1)) begin
            pt_dist <= sq_root_next;
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          dist_sum <= sum_next;
          count    <= count_next;
          dv_q     <= sum_next;
          dv_rem   <= '0;
          step     <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          dv_q   <= dv_q_next;
          dv_rem <= dv_ge ? mnds_pkg::CNT_W'(dv_rem2 - {1'b0, count})
                          : dv_rem2[mnds_pkg::CNT_W-1:0];
          step   <= step + 1'b1;
          if (step == mnds_pkg::STEP_W'(mnds_pkg::DIV_STEPS - 1)) begin
            res_valid       <= 1'b1;
            point_distance  <= pt_dist;
            mean_distance   <= mean_calc;
            mean_valid      <= cur_last;
            empty_reference <= cur_empty;
            if (cur_last) begin
              dist_sum <= '0;
              count    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/mean_nearest_distance_to_set.sv */
// Channel        | Handshake                         | Payload
// ---------------+-----------------------------------+-------------------------------------
// item in        | start & !busy                     | command, ref_index, coord_index,
//                |                                   | coord_value, last_coord, last_point
// result out     | result_valid (one-cycle strobe)   | point_distance, mean_distance,
//                |                                   | mean_valid, empty_reference
// registers      | psel & penable & pwrite (pready=1)| paddr, pwdata, prdata
//
// Reference writes and non-final query coordinates are taken while the back end is idle.
// A last coordinate starts a search over R reference rows of D coordinates
// each, one shared multiply-accumulate per cycle over the store's
// single read port, then 32 square-root steps and 49 for sum and mean.
// A two-entry queue takes items while the back end works; busy marks it full.
// rst is synchronous and clears queue, state, sum and count; the store and
// the query buffer hold whatever was written. Results cannot be stalled.
`default_nettype none
module mean_nearest_distance_to_set (
  input  logic        clk,
  input  logic        rst,
  // item transfer
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  ref_index,
  input  logic [2:0]  coord_index,
  input  logic [31:0] coord_value,
  input  logic        last_coord,
  input  logic        last_point,
  // result transfer
  output logic        result_valid,
  output logic [31:0] point_distance,
  output logic [31:0] mean_distance,
  output logic        mean_valid,
  output logic        empty_reference,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mnds_pkg::cfg_t  cfg;
  mnds_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;
  logic            reg_write;

  // Register block: dimension_count at 0, reference_count at 4
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dimension_count <= mnds_pkg::DIMS_W'(2);
      cfg.reference_count <= '0;
    end else if (reg_write) begin
      unique case (paddr[2])
        mnds_pkg::REG_DIM: cfg.dimension_count <= pwdata[mnds_pkg::DIMS_W-1:0];
        mnds_pkg::REG_REF: cfg.reference_count <= pwdata[mnds_pkg::REFS_W-1:0];
        default:           cfg.reference_count <= cfg.reference_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mnds_pkg::REG_DIM: prdata = 32'(cfg.dimension_count);
      mnds_pkg::REG_REF: prdata = 32'(cfg.reference_count);
      default:           prdata = '0;
    endcase
  end

  // Front end: takes each transfer, tags it and queues it
  mnds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .ref_index   (ref_index),
    .coord_index (coord_index),
    .coord_value (coord_value),
    .last_coord  (last_coord),
    .last_point  (last_point),
    .busy        (busy),
    .item        (item),
    .item_valid  (item_valid),
    .item_pop    (item_pop)
  );

  // Back end: store writes, nearest-row search, sqrt, running mean
  mnds_back u_back (
    .clk             (clk),
    .rst             (rst),
    .item            (item),
    .item_valid      (item_valid),
    .item_pop        (item_pop),
    .cfg             (cfg),
    .res_valid       (result_valid),
    .point_distance  (point_distance),
    .mean_distance   (mean_distance),
    .mean_valid      (mean_valid),
    .empty_reference (empty_reference)
  );

endmodule
`default_nettype wire

/* rtl/mnds_checker.sv */
`default_nettype none
`include "mean_nearest_distance_to_set_defines.svh"
module mnds_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic [31:0] point_distance,
  input logic [31:0] mean_distance,
  input logic        mean_valid,
  input logic        empty_reference,
  input logic        pready
);

  `MNDS_ASSERT_NXT(a_strobe_single, clk, rst, result_valid, !result_valid)
  `MNDS_ASSERT_IMP(a_empty_dist, clk, rst, result_valid && empty_reference, point_distance == 32'hFFFFFFFF)
  `MNDS_ASSERT_IMP(a_empty_mean, clk, rst, result_valid && empty_reference && mean_valid, mean_distance == 32'hFFFFFFFF)
  `MNDS_ASSERT_IMP(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind mean_nearest_distance_to_set mnds_checker u_mnds_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result_valid),
  .point_distance  (point_distance),
  .mean_distance   (mean_distance),
  .mean_valid      (mean_valid),
  .empty_reference (empty_reference),
  .pready          (pready)
);
`default_nettype wire

/* tb/mean_nearest_distance_to_set_checker.sv */
`timescale 1ns / 1ps
module mean_nearest_distance_to_set_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [7:0]  ref_index,
  input  logic [2:0]  coord_index,
  input  logic [31:0] coord_value,
  input  logic        last_coord,
  input  logic        last_point,
  input  logic        result_valid,
  input  logic [31:0] point_distance,
  input  logic [31:0] mean_distance,
  input  logic        mean_valid,
  input  logic        empty_reference,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);

  localparam logic CMD_QUERY = 1'b1;
  localparam logic [47:0] SUM_SAT = '1;
  localparam logic [15:0] CNT_SAT = '1;

  typedef struct {
    logic [31:0] pt_dist;
    logic [31:0] mean;
    logic        mean_ok;
    logic        empty;
  } nearest_t;

  logic [31:0] ref_rows [mnds_pkg::RAM_DEPTH];
  logic [31:0] query_coords [mnds_pkg::DIM_MAX];
  logic [47:0] dist_total;
  logic [15:0] points_seen;
  logic [mnds_pkg::DIMS_W-1:0] dims_cfg;
  logic [mnds_pkg::REFS_W-1:0] refs_cfg;
  nearest_t    awaited [$];

  // squared distance to one row, saturating at 2^64-1
  function automatic logic [63:0] row_sq_dist(int row, int nd);
    longint      d;
    logic [63:0] mag;
    logic [64:0] acc;
    acc = '0;
    for (int c = 0; c < nd; c++) begin
      d = longint'($signed(query_coords[c]))
          - longint'($signed(ref_rows[row*mnds_pkg::DIM_MAX + c]));
      mag = (d < 0) ? 64'(-d) : 64'(d);
      acc = acc + {1'b0, mag * mag};
      if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return acc[63:0];
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = 64'(r | (32'd1 << b));
      if (t * t <= n) r = t[31:0];
    end
    return r;
  endfunction

  function automatic nearest_t predict_point(logic lp);
    nearest_t    o;
    int          nd, nr;
    logic [63:0] best, s;
    logic [48:0] acc;
    logic [47:0] m;
    nd = (dims_cfg == 0) ? 1 :
         (dims_cfg > mnds_pkg::DIM_MAX) ? mnds_pkg::DIM_MAX : int'(dims_cfg);
    nr = (refs_cfg > mnds_pkg::REF_MAX) ? mnds_pkg::REF_MAX : int'(refs_cfg);
    o.empty = (nr == 0);
    if (o.empty) begin
      o.pt_dist = mnds_pkg::DIST_MAX;
    end else begin
      best = '1;
      for (int r = 0; r < nr; r++) begin
        s = row_sq_dist(r, nd);
        if (s < best) best = s;
      end
      o.pt_dist = floor_root(best);
    end
    acc = {1'b0, dist_total} + 49'(o.pt_dist);
    dist_total = acc[48] ? SUM_SAT : acc[47:0];
    if (points_seen != CNT_SAT) points_seen++;
    m = dist_total / 48'(points_seen);
    o.mean = (m > 48'hFFFF_FFFF) ? mnds_pkg::DIST_MAX : m[31:0];
    if (lp && o.empty) o.mean = mnds_pkg::DIST_MAX;
    o.mean_ok = lp;
    if (lp) begin
      dist_total = '0;
      points_seen = '0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    nearest_t want;
    if (rst) begin
      dist_total = '0;
      points_seen = '0;
      dims_cfg = 4'd2;
      refs_cfg = '0;
      awaited.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == mnds_pkg::REG_DIM) dims_cfg = pwdata[mnds_pkg::DIMS_W-1:0];
        else                               refs_cfg = pwdata[mnds_pkg::REFS_W-1:0];
      end
      if (start && !busy) begin
        if (command != CMD_QUERY) begin
          ref_rows[{ref_index, coord_index}] = coord_value;
        end else begin
          query_coords[coord_index] = coord_value;
          if (last_coord) awaited.push_back(predict_point(last_point));
        end
      end
      if (result_valid) begin
        if (awaited.size() == 0) begin
          $error("result with nothing awaited: point_distance %h", point_distance);
          fails++;
        end else begin
          want = awaited.pop_front();
          if (point_distance !== want.pt_dist) begin
            $error("point_distance: expected %h, actual %h", want.pt_dist, point_distance);
            fails++;
          end
          if (mean_distance !== want.mean) begin
            $error("mean_distance: expected %h, actual %h", want.mean, mean_distance);
            fails++;
          end
          if (mean_valid !== want.mean_ok) begin
            $error("mean_valid: expected %b, actual %b", want.mean_ok, mean_valid);
            fails++;
          end
          if (empty_reference !== want.empty) begin
            $error("empty_reference: expected %b, actual %b", want.empty, empty_reference);
            fails++;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule

/* tb/mean_nearest_distance_to_set_test.sv */
`timescale 1ns / 1ps
module mean_nearest_distance_to_set_test;

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam int   ITEMS       = 1250;
  localparam int   CALM_FROM   = 1100;   // no idling past this many items
  localparam int   STALL_LIMIT = 30000;  // well above a full 256 x 8 search plus queue

  logic        clk, rst;
  logic        start, busy;
  logic        command;
  logic [7:0]  ref_index;
  logic [2:0]  coord_index;
  logic [31:0] coord_value;
  logic        last_coord, last_point;
  logic        result_valid;
  logic [31:0] point_distance, mean_distance;
  logic        mean_valid, empty_reference;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  int fails, pending;
  int sent;
  bit calm;
  int quiet_cycles;
  bit written [mnds_pkg::RAM_DEPTH];

  mean_nearest_distance_to_set u_top (.*);

  mean_nearest_distance_to_set_checker u_check (
    .clk, .rst, .start, .busy, .command, .ref_index, .coord_index, .coord_value,
    .last_coord, .last_point, .result_valid, .point_distance, .mean_distance,
    .mean_valid, .empty_reference, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles with no item or result transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** mean_nearest_distance_to_set: FAILED **");
      $finish;
    end
  end

  // mix of full-range, extreme and small Q16.16 values
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endcase
  endfunction

  // one item transfer, with an optional random gap first; start stays high
  // across back-to-back transfers
  task automatic send_item(input logic cmd, input logic [7:0] row, input logic [2:0] col,
                           input logic [31:0] val, input logic lc, input logic lp);
    int gap;
    calm = (sent >= CALM_FROM);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    ref_index   <= row;
    coord_index <= col;
    coord_value <= val;
    last_coord  <= lc;
    last_point  <= lp;
    do @(posedge clk); while (busy);
    if (cmd == CMD_REF) written[{row, col}] = 1'b1;
    sent++;
  endtask

  // write every store entry a search over these rows and columns would read
  task automatic cover_rows(input int nr, input int nd);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nd; c++)
        if (!written[r*mnds_pkg::DIM_MAX + c])
          send_item(CMD_REF, 8'(r), 3'(c), pick_coord(), 1'($urandom), 1'($urandom));
  endtask

  // coordinates of one query point in order; markers on the others are noise
  task automatic send_point(input int nd, input logic lp);
    for (int c = 0; c < nd; c++)
      send_item(CMD_QUERY, 8'($urandom), 3'(c), pick_coord(), c == nd - 1,
                (c == nd - 1) ? lp : 1'($urandom));
  endtask

  // hold off until every awaited result is in, then let queued writes settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int nd, nr, phase_len, kind;
    start <= 1'b0; command <= CMD_REF; ref_index <= '0; coord_index <= '0;
    coord_value <= '0; last_coord <= 1'b0; last_point <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    rst <= 1'b1;
    calm = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the query buffer so that no search meets an unwritten coordinate;
    // stray markers on these are ignored
    for (int c = 0; c < mnds_pkg::DIM_MAX; c++)
      send_item(CMD_QUERY, 8'($urandom), 3'(c), pick_coord(), 1'b0, 1'($urandom));

    // empty reference set after reset: maximum distance, then maximum mean
    send_item(CMD_QUERY, 8'h00, 3'd0, 32'h0001_0000, 1'b1, 1'b0);
    send_item(CMD_QUERY, 8'hFF, 3'd1, 32'hFFFF_0000, 1'b1, 1'b1);
    drain();

    // opposite extremes on all eight axes: squared sum saturates
    reg_write(mnds_pkg::REG_DIM, 32'd8);
    reg_write(mnds_pkg::REG_REF, 32'd1);
    for (int c = 0; c < mnds_pkg::DIM_MAX; c++)
      send_item(CMD_REF, 8'h00, 3'(c), 32'h7FFF_FFFF, 1'b1, 1'b1);
    for (int c = 0; c < mnds_pkg::DIM_MAX; c++)
      send_item(CMD_QUERY, 8'h00, 3'(c), 32'h8000_0000, c == mnds_pkg::DIM_MAX - 1, 1'b1);
    // a random point opens the next set
    send_point(mnds_pkg::DIM_MAX, 1'b0);
    drain();

    // out-of-range registers: dimension 0 acts as 1, count above the store
    reg_write(mnds_pkg::REG_DIM, 32'h0000_0000);
    reg_write(mnds_pkg::REG_REF, 32'hFFFF_FFFF);
    cover_rows(mnds_pkg::REF_MAX, 1);
    send_item(CMD_QUERY, 8'h00, 3'd7, 32'h0000_0000, 1'b1, 1'b1);
    drain();
    reg_write(mnds_pkg::REG_DIM, 32'hFFFF_FFFF);
    reg_write(mnds_pkg::REG_REF, 32'd2);
    cover_rows(2, mnds_pkg::DIM_MAX);
    send_item(CMD_QUERY, 8'h00, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drain();

    // random phases, each with its own register setting
    while (sent < ITEMS) begin
      case ($urandom_range(0, 9))
        0:       nd = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
        1:       nd = 8;
        2:       nd = 1;
        default: nd = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0:       nr = 0;
        1:       nr = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
        2:       nr = $urandom_range(1, 64);
        default: nr = $urandom_range(1, 12);
      endcase
      // a full-depth search stays on one coordinate to keep the store fill short
      if (nr > 64) nd = $urandom_range(0, 1);
      reg_write(mnds_pkg::REG_DIM, {$urandom} & ~32'hF | 32'(nd));
      reg_write(mnds_pkg::REG_REF, {$urandom} & ~32'h1FF | 32'(nr));
      nd = (nd == 0) ? 1 : (nd > mnds_pkg::DIM_MAX) ? mnds_pkg::DIM_MAX : nd;
      nr = (nr > mnds_pkg::REF_MAX) ? mnds_pkg::REF_MAX : nr;
      cover_rows(nr, nd);
      phase_len = (nr > 64) ? 12 : 48;
      for (int k = 0; k < phase_len && sent < ITEMS; ) begin
        kind = $urandom_range(0, 9);
        if (kind < 6 && nd <= phase_len - k) begin
          send_point(nd, $urandom_range(0, 3) == 0);
          k += nd;
        end else if (kind < 9) begin
          send_item(CMD_REF, 8'($urandom_range(0, (nr > 0) ? nr - 1 : 255)),
                    3'($urandom_range(0, nd - 1)), pick_coord(), 1'($urandom), 1'($urandom));
          k++;
        end else begin
          // noise: loose coordinates, arbitrary markers, any row
          send_item(1'($urandom), 8'($urandom), 3'($urandom), pick_coord(),
                    $urandom_range(0, 2) == 0, 1'($urandom));
          k++;
        end
      end
      drain();
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("** mean_nearest_distance_to_set: PASSED **");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("** mean_nearest_distance_to_set: FAILED **");
    end
    $finish;
  end

endmodule
